FILE: rtl/mptt_pkg.sv
// mptt_pkg: widths, payload structs and sideband types for move_point_towards_target
// no dependencies; imported by every module of the block
`default_nettype none

package mptt_pkg;

    localparam int COORD_BITS = 32;
    localparam int DIF_BITS   = COORD_BITS + 1;          // exact goal - cur
    localparam int SQ_BITS    = 2 * DIF_BITS;            // one squared component
    localparam int RAD_BITS   = SQ_BITS + 2;             // sum of three squares
    localparam int SSQ_BITS   = 2 * (COORD_BITS - 1);    // square of a non-negative step
    localparam int ROOT_BITS  = RAD_BITS / 2;            // floor sqrt of the sum
    localparam int SREM_BITS  = ROOT_BITS + 3;           // sqrt partial remainder
    localparam int NUM_BITS   = DIF_BITS + COORD_BITS;   // |d| * |step|
    localparam int QUO_BITS   = COORD_BITS;              // quotient magnitude <= |step|
    localparam int DREM_BITS  = ROOT_BITS + 1;           // divider partial remainder
    localparam int LANES      = 3;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cur_x;
        logic signed [COORD_BITS-1:0] cur_y;
        logic signed [COORD_BITS-1:0] cur_z;
        logic signed [COORD_BITS-1:0] goal_x;
        logic signed [COORD_BITS-1:0] goal_y;
        logic signed [COORD_BITS-1:0] goal_z;
        logic signed [COORD_BITS-1:0] step_len;
    } req_t;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] new_x;
        logic signed [COORD_BITS-1:0] new_y;
        logic signed [COORD_BITS-1:0] new_z;
        logic                         reached;
    } rsp_t;

    // carried alongside the divider
    typedef struct packed {
        logic                                reached;
        logic [LANES-1:0]                    neg;
        logic [LANES-1:0][COORD_BITS-1:0]    cur;
        logic [LANES-1:0][COORD_BITS-1:0]    goal;
    } div_side_t;

    // carried alongside the square root
    typedef struct packed {
        logic [LANES-1:0][NUM_BITS-1:0] num;
        div_side_t                      pass;
    } sq_side_t;

endpackage

`default_nettype wire

FILE: rtl/mptt_front.sv
// mptt_front: difference vector, squares, squared distance, products and reach test
// four register stages; depends on mptt_pkg
`default_nettype none

module mptt_front
    import mptt_pkg::*;
(
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              adv,
    input  wire logic              in_valid,
    input  wire req_t              in_data,
    output logic                   out_valid,
    output logic [RAD_BITS-1:0]    out_rad,
    output sq_side_t               out_sb
);

    logic [LANES-1:0][COORD_BITS-1:0] cur_in, goal_in;

    // stage 1
    logic                             v1_reg;
    logic [LANES-1:0][DIF_BITS-1:0]   dif_reg, dif_next;
    logic [COORD_BITS-1:0]            step1_reg;
    logic [LANES-1:0][COORD_BITS-1:0] cur1_reg, goal1_reg;

    // stage 2
    logic                             v2_reg;
    logic [LANES-1:0][DIF_BITS-1:0]   mag_reg, mag_next;
    logic [LANES-1:0][SQ_BITS-1:0]    sq_reg, sq_next;
    logic [SSQ_BITS-1:0]              ssq2_reg, ssq2_next;
    logic [COORD_BITS-1:0]            smag_reg, smag_next;
    logic                             sneg2_reg;
    logic [LANES-1:0]                 neg2_reg, neg2_next;
    logic [LANES-1:0][COORD_BITS-1:0] cur2_reg, goal2_reg;

    // stage 3
    logic                             v3_reg;
    logic [RAD_BITS-1:0]              dsq_reg, dsq_next;
    logic [LANES-1:0][NUM_BITS-1:0]   num_reg, num_next;
    logic [SSQ_BITS-1:0]              ssq3_reg;
    logic                             sneg3_reg;
    logic [LANES-1:0]                 neg3_reg;
    logic [LANES-1:0][COORD_BITS-1:0] cur3_reg, goal3_reg;

    // stage 4
    logic                             v4_reg;
    logic [RAD_BITS-1:0]              rad_reg;
    logic                             reached_reg, reached_next;
    sq_side_t                         sb_reg;

    assign cur_in  = {in_data.cur_z, in_data.cur_y, in_data.cur_x};
    assign goal_in = {in_data.goal_z, in_data.goal_y, in_data.goal_x};

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            dif_next[i] = {goal_in[i][COORD_BITS-1], goal_in[i]}
                        - {cur_in[i][COORD_BITS-1], cur_in[i]};
        end
    end

    always_comb begin
        for (int i = 0; i < LANES; i++) begin
            mag_next[i]  = dif_reg[i][DIF_BITS-1] ? (~dif_reg[i] + 1'b1) : dif_reg[i];
            sq_next[i]   = SQ_BITS'(mag_next[i]) * SQ_BITS'(mag_next[i]);
            neg2_next[i] = dif_reg[i][DIF_BITS-1] ^ step1_reg[COORD_BITS-1];
        end
        smag_next = step1_reg[COORD_BITS-1] ? (~step1_reg + 1'b1) : step1_reg;
        // a negative step reaches the goal only at zero distance
        ssq2_next = step1_reg[COORD_BITS-1] ? '0
                  : SSQ_BITS'(step1_reg[COORD_BITS-2:0])
                    * SSQ_BITS'(step1_reg[COORD_BITS-2:0]);
    end

    always_comb begin
        dsq_next = RAD_BITS'(sq_reg[0]) + RAD_BITS'(sq_reg[1]) + RAD_BITS'(sq_reg[2]);
        for (int i = 0; i < LANES; i++) begin
            num_next[i] = NUM_BITS'(mag_reg[i]) * NUM_BITS'(smag_reg);
        end
    end

    always_comb begin
        reached_next = (dsq_reg == '0)
                     || (!sneg3_reg && (dsq_reg <= RAD_BITS'(ssq3_reg)));
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            dif_reg   <= dif_next;
            step1_reg <= in_data.step_len;
            cur1_reg  <= cur_in;
            goal1_reg <= goal_in;

            mag_reg   <= mag_next;
            sq_reg    <= sq_next;
            ssq2_reg  <= ssq2_next;
            smag_reg  <= smag_next;
            sneg2_reg <= step1_reg[COORD_BITS-1];
            neg2_reg  <= neg2_next;
            cur2_reg  <= cur1_reg;
            goal2_reg <= goal1_reg;

            dsq_reg   <= dsq_next;
            num_reg   <= num_next;
            ssq3_reg  <= ssq2_reg;
            sneg3_reg <= sneg2_reg;
            neg3_reg  <= neg2_reg;
            cur3_reg  <= cur2_reg;
            goal3_reg <= goal2_reg;

            rad_reg             <= dsq_reg;
            reached_reg         <= reached_next;
            sb_reg.num          <= num_reg;
            sb_reg.pass.reached <= reached_next;
            sb_reg.pass.neg     <= neg3_reg;
            sb_reg.pass.cur     <= cur3_reg;
            sb_reg.pass.goal    <= goal3_reg;
        end
    end

    assign out_valid = v4_reg;
    assign out_rad   = rad_reg;
    assign out_sb    = sb_reg;

    // reached copy kept for checking the sideband
    property p_reach_copy;
        @(posedge aclk) disable iff (!aresetn) v4_reg |-> (reached_reg == sb_reg.pass.reached);
    endproperty
    a_reach_copy: assert property (p_reach_copy) else $error("reached sideband mismatch");

    property p_zero_reached;
        @(posedge aclk) disable iff (!aresetn) (v4_reg && rad_reg == '0) |-> reached_reg;
    endproperty
    a_zero_reached: assert property (p_zero_reached) else $error("zero distance not reached");

    property p_stall_hold;
        @(posedge aclk) disable iff (!aresetn) !adv |=> $stable(rad_reg) && $stable(v4_reg);
    endproperty
    a_stall_hold: assert property (p_stall_hold) else $error("front moved during stall");

endmodule

`default_nettype wire

FILE: rtl/mptt_isqrt.sv
// mptt_isqrt: pipelined floor square root, one root bit per register stage
// depends on mptt_pkg; sideband bits travel unchanged beside the root
`default_nettype none

module mptt_isqrt
    import mptt_pkg::*;
#(
    parameter int SB_BITS = 1
) (
    input  wire logic                 aclk,
    input  wire logic                 aresetn,
    input  wire logic                 adv,
    input  wire logic                 in_valid,
    input  wire logic [RAD_BITS-1:0]  in_rad,
    input  wire logic [SB_BITS-1:0]   in_sb,
    output logic                      out_valid,
    output logic [ROOT_BITS-1:0]      out_root,
    output logic [SB_BITS-1:0]        out_sb
);

    logic                 val_reg  [1:ROOT_BITS];
    logic [RAD_BITS-1:0]  rad_reg  [1:ROOT_BITS];
    logic [SREM_BITS-1:0] rem_reg  [1:ROOT_BITS];
    logic [ROOT_BITS-1:0] root_reg [1:ROOT_BITS];
    logic [SB_BITS-1:0]   sb_reg   [1:ROOT_BITS];

    for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
        logic                 v_in;
        logic [RAD_BITS-1:0]  rad_in;
        logic [SREM_BITS-1:0] rem_in;
        logic [ROOT_BITS-1:0] root_in;
        logic [SB_BITS-1:0]   sb_in;
        logic [SREM_BITS-1:0] rem_sh, trial, rem_next;
        logic [ROOT_BITS-1:0] root_next;
        logic [RAD_BITS-1:0]  rad_next;
        logic                 ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign rad_in  = in_rad;
            assign rem_in  = '0;
            assign root_in = '0;
            assign sb_in   = in_sb;
        end else begin : g_rest
            assign v_in    = val_reg[k];
            assign rad_in  = rad_reg[k];
            assign rem_in  = rem_reg[k];
            assign root_in = root_reg[k];
            assign sb_in   = sb_reg[k];
        end

        // bring down the next pair of radicand bits and try root*4+1
        always_comb begin
            rem_sh    = {rem_in[SREM_BITS-3:0], rad_in[RAD_BITS-1 -: 2]};
            trial     = {1'b0, root_in, 2'b01};
            ge        = (rem_sh >= trial);
            rem_next  = ge ? (rem_sh - trial) : rem_sh;
            root_next = {root_in[ROOT_BITS-2:0], ge};
            rad_next  = {rad_in[RAD_BITS-3:0], 2'b00};
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[k+1] <= 1'b0;
            end else if (adv) begin
                val_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rad_reg[k+1]  <= rad_next;
                rem_reg[k+1]  <= rem_next;
                root_reg[k+1] <= root_next;
                sb_reg[k+1]   <= sb_in;
            end
        end
    end

    assign out_valid = val_reg[ROOT_BITS];
    assign out_root  = root_reg[ROOT_BITS];
    assign out_sb    = sb_reg[ROOT_BITS];

endmodule

`default_nettype wire

FILE: rtl/mptt_div3.sv
// mptt_div3: three pipelined restoring dividers sharing one divisor, one quotient bit a stage
// depends on mptt_pkg; sideband bits travel unchanged beside the quotients
`default_nettype none

module mptt_div3
    import mptt_pkg::*;
#(
    parameter int SB_BITS = 1
) (
    input  wire logic                               aclk,
    input  wire logic                               aresetn,
    input  wire logic                               adv,
    input  wire logic                               in_valid,
    input  wire logic [ROOT_BITS-1:0]               in_dist,
    input  wire logic [LANES-1:0][NUM_BITS-1:0]     in_num,
    input  wire logic [SB_BITS-1:0]                 in_sb,
    output logic                                    out_valid,
    output logic [LANES-1:0][QUO_BITS-1:0]          out_quo,
    output logic [SB_BITS-1:0]                      out_sb
);

    localparam int PAD_BITS = DREM_BITS - (NUM_BITS - QUO_BITS);

    logic                                 val_reg  [1:QUO_BITS];
    logic [ROOT_BITS-1:0]                 dist_reg [1:QUO_BITS];
    logic [LANES-1:0][DREM_BITS-1:0]      rem_reg  [1:QUO_BITS];
    logic [LANES-1:0][QUO_BITS-1:0]       lo_reg   [1:QUO_BITS];
    logic [LANES-1:0][QUO_BITS-1:0]       quo_reg  [1:QUO_BITS];
    logic [SB_BITS-1:0]                   sb_reg   [1:QUO_BITS];

    for (genvar k = 0; k < QUO_BITS; k++) begin : g_stage
        logic                             v_in;
        logic [ROOT_BITS-1:0]             dist_in;
        logic [LANES-1:0][DREM_BITS-1:0]  rem_in, rem_next;
        logic [LANES-1:0][QUO_BITS-1:0]   lo_in, lo_next, quo_in, quo_next;
        logic [SB_BITS-1:0]               sb_in;
        logic [DREM_BITS-1:0]             rem_sh;
        logic                             ge;

        if (k == 0) begin : g_first
            assign v_in    = in_valid;
            assign dist_in = in_dist;
            assign sb_in   = in_sb;
            // high part of the numerator is already below the divisor
            for (genvar i = 0; i < LANES; i++) begin : g_lane
                assign rem_in[i] = {{PAD_BITS{1'b0}}, in_num[i][NUM_BITS-1:QUO_BITS]};
                assign lo_in[i]  = in_num[i][QUO_BITS-1:0];
                assign quo_in[i] = '0;
            end
        end else begin : g_rest
            assign v_in    = val_reg[k];
            assign dist_in = dist_reg[k];
            assign rem_in  = rem_reg[k];
            assign lo_in   = lo_reg[k];
            assign quo_in  = quo_reg[k];
            assign sb_in   = sb_reg[k];
        end

        always_comb begin
            rem_next = rem_in;
            lo_next  = lo_in;
            quo_next = quo_in;
            for (int i = 0; i < LANES; i++) begin
                rem_sh      = {rem_in[i][DREM_BITS-2:0], lo_in[i][QUO_BITS-1]};
                ge          = (rem_sh >= {1'b0, dist_in});
                rem_next[i] = ge ? (rem_sh - {1'b0, dist_in}) : rem_sh;
                lo_next[i]  = {lo_in[i][QUO_BITS-2:0], 1'b0};
                quo_next[i] = {quo_in[i][QUO_BITS-2:0], ge};
            end
        end

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                val_reg[k+1] <= 1'b0;
            end else if (adv) begin
                val_reg[k+1] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                dist_reg[k+1] <= dist_in;
                rem_reg[k+1]  <= rem_next;
                lo_reg[k+1]   <= lo_next;
                quo_reg[k+1]  <= quo_next;
                sb_reg[k+1]   <= sb_in;
            end
        end
    end

    assign out_valid = val_reg[QUO_BITS];
    assign out_quo   = quo_reg[QUO_BITS];
    assign out_sb    = sb_reg[QUO_BITS];

endmodule

`default_nettype wire

FILE: rtl/move_point_towards_target.sv
// move_point_towards_target: streaming fixed-point 3d move-towards unit (top level)
// depends on mptt_pkg, mptt_front, mptt_isqrt, mptt_div3
//
// usage
//   s_ channel: one request per accepted beat (s_valid && s_ready) carrying the
//   current point, the goal point and the step length, all signed Q16.16
//   m_ channel: one response per request, in request order, with the moved point
//   (saturated to the coordinate range) and the reached flag
//   stages: a request crosses these in order from acceptance to m_valid
//     4 front stages (difference, squares, sum and products, reach test)
//     34 square root stages, one root bit each
//     32 divider stages, one quotient bit each, three lanes side by side
//     1 output stage (sign, add, saturate, goal select)
//   throughput: one request per cycle unless m_ready stalls the output; the pipeline stages set this figure
//   stall: the whole pipeline advances together; when m_valid is high and
//     m_ready low every stage holds, s_ready drops, and nothing is lost or
//     repeated; an empty output register keeps the pipeline moving
//   reset: aresetn low clears every valid bit, so no response appears until a
//     new request has crossed the full pipeline
`default_nettype none

module move_point_towards_target
    import mptt_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  wire logic s_valid,
    output logic      s_ready,
    input  wire req_t s_data,
    output logic      m_valid,
    input  wire logic m_ready,
    output rsp_t      m_data
);

    localparam int SQ_SB_BITS  = $bits(sq_side_t);
    localparam int DIV_SB_BITS = $bits(div_side_t);

    // global advance: move when the output register is empty or being drained
    logic adv;

    logic                       fr_valid;
    logic [RAD_BITS-1:0]        fr_rad;
    sq_side_t                   fr_sb;

    logic                       sq_valid;
    logic [ROOT_BITS-1:0]       sq_root;
    logic [SQ_SB_BITS-1:0]      sq_sb_bits;
    sq_side_t                   sq_sb;

    logic                              dv_valid;
    logic [LANES-1:0][QUO_BITS-1:0]    dv_quo;
    logic [DIV_SB_BITS-1:0]            dv_sb_bits;
    div_side_t                         dv_sb;

    logic [LANES-1:0][COORD_BITS-1:0]  res_next;
    logic                              m_valid_reg;
    rsp_t                              m_data_reg, m_data_next;

    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    // difference, squared distance, numerators and reach test
    mptt_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (s_valid),
        .in_data   (s_data),
        .out_valid (fr_valid),
        .out_rad   (fr_rad),
        .out_sb    (fr_sb)
    );

    // distance = floor sqrt of the squared length
    mptt_isqrt #(
        .SB_BITS (SQ_SB_BITS)
    ) u_isqrt (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (fr_valid),
        .in_rad    (fr_rad),
        .in_sb     (fr_sb),
        .out_valid (sq_valid),
        .out_root  (sq_root),
        .out_sb    (sq_sb_bits)
    );

    assign sq_sb = sq_side_t'(sq_sb_bits);

    // |d| * |step| / distance per coordinate; garbage when reached, never used then
    mptt_div3 #(
        .SB_BITS (DIV_SB_BITS)
    ) u_div3 (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .adv       (adv),
        .in_valid  (sq_valid),
        .in_dist   (sq_root),
        .in_num    (sq_sb.num),
        .in_sb     (sq_sb.pass),
        .out_valid (dv_valid),
        .out_quo   (dv_quo),
        .out_sb    (dv_sb_bits)
    );

    assign dv_sb = div_side_t'(dv_sb_bits);

    // apply the sign, add to the current point and clamp to the coordinate range
    always_comb begin
        logic [COORD_BITS+1:0] q_ext;
        logic [COORD_BITS+1:0] sum;
        for (int i = 0; i < LANES; i++) begin
            q_ext = {2'b00, dv_quo[i]};
            if (dv_sb.neg[i]) begin
                q_ext = ~q_ext + 1'b1;
            end
            sum = {{2{dv_sb.cur[i][COORD_BITS-1]}}, dv_sb.cur[i]} + q_ext;
            if (sum[COORD_BITS+1:COORD_BITS-1] == 3'b000
                || sum[COORD_BITS+1:COORD_BITS-1] == 3'b111) begin
                res_next[i] = sum[COORD_BITS-1:0];
            end else if (sum[COORD_BITS+1]) begin
                res_next[i] = {1'b1, {(COORD_BITS-1){1'b0}}};
            end else begin
                res_next[i] = {1'b0, {(COORD_BITS-1){1'b1}}};
            end
            // goal is returned untouched when it is within reach
            if (dv_sb.reached) begin
                res_next[i] = dv_sb.goal[i];
            end
        end
        m_data_next.new_x   = res_next[0];
        m_data_next.new_y   = res_next[1];
        m_data_next.new_z   = res_next[2];
        m_data_next.reached = dv_sb.reached;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_data_reg <= m_data_next;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // a request accepted with the pipeline stalled would be lost
    property p_accept_moves;
        @(posedge aclk) disable iff (!aresetn) (s_valid && s_ready) |-> adv;
    endproperty
    a_accept_moves: assert property (p_accept_moves) else $error("request taken during stall");

    // a held response keeps the divider output frozen as well
    property p_stall_freezes;
        @(posedge aclk) disable iff (!aresetn)
            (m_valid && !m_ready) |=> $stable(dv_quo) && $stable(dv_valid);
    endproperty
    a_stall_freezes: assert property (p_stall_freezes) else $error("pipeline moved in stall");

    // a reached response carries the goal exactly; the check looks at new_x
    property p_reached_goal;
        @(posedge aclk) disable iff (!aresetn)
            (adv && dv_valid && dv_sb.reached) |=> (m_data.new_x == $past(dv_sb.goal[0]));
    endproperty
    a_reached_goal: assert property (p_reached_goal) else $error("reached without goal");

endmodule

`default_nettype wire

FILE: verif/tb.sv
// tb: self-checking testbench for move_point_towards_target
// depends on mptt_pkg and the rtl of the block; predicts each response in place
`timescale 1ns / 1ps
`default_nettype none

module tb;
    import mptt_pkg::*;

    localparam int CLK_HALF  = 5;
    localparam int LATENCY   = 71;
    localparam int N_RANDOM  = 1630;
    localparam longint CYCLE_LIMIT = 400000;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    req_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    rsp_t m_data;

    // request queue filled by the test sequence, expected responses filled at acceptance
    req_t pending_reqs[$];
    rsp_t expected_moves[$];
    int   n_errors = 0;
    longint n_cycles = 0;
    bit   stim_done = 1'b0;
    bit   hold_send = 1'b0;   // sender paused until the pipe drains
    bit   no_idle = 1'b0;     // stretch with no idling on either side

    move_point_towards_target uut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // floor integer square root of a 128-bit value, bit by bit
    function automatic logic [63:0] isqrt128(input logic [127:0] n);
        logic [63:0] r;
        logic [63:0] t;
        r = '0;
        for (int i = 63; i >= 0; i--) begin
            t = r | (64'd1 << i);
            if (128'(t) * 128'(t) <= n) r = t;
        end
        return r;
    endfunction

    // expected moved point for one request
    function automatic rsp_t predict_move(input req_t rq);
        rsp_t rs;
        logic signed [COORD_BITS-1:0] cur[3];
        logic signed [COORD_BITS-1:0] goal[3];
        logic signed [COORD_BITS:0]   dif[3];
        logic [COORD_BITS:0]          dmag[3];
        logic [127:0] dsq;
        logic [127:0] ssq;
        logic [63:0]  droot;
        logic [63:0]  smag;
        logic [127:0] qm;
        logic signed [65:0] sum;
        logic signed [COORD_BITS-1:0] step;
        logic signed [COORD_BITS-1:0] outv[3];
        cur[0] = rq.cur_x;  cur[1] = rq.cur_y;  cur[2] = rq.cur_z;
        goal[0] = rq.goal_x; goal[1] = rq.goal_y; goal[2] = rq.goal_z;
        step = rq.step_len;
        dsq = '0;
        for (int i = 0; i < 3; i++) begin
            dif[i] = 33'(goal[i]) - 33'(cur[i]);
            dmag[i] = dif[i] < 0 ? 33'(-dif[i]) : 33'(dif[i]);
            dsq += 128'(dmag[i]) * 128'(dmag[i]);
        end
        smag = step < 0 ? 64'(-65'(step)) : 64'(step);
        ssq = 128'(smag) * 128'(smag);
        if (dsq == 0 || (step >= 0 && dsq <= ssq)) begin
            rs.new_x = goal[0]; rs.new_y = goal[1]; rs.new_z = goal[2];
            rs.reached = 1'b1;
            return rs;
        end
        droot = isqrt128(dsq);
        for (int i = 0; i < 3; i++) begin
            qm = (128'(dmag[i]) * 128'(smag)) / 128'(droot);
            sum = 66'(cur[i]);
            if ((dif[i] < 0) != (step < 0)) sum = sum - 66'(qm);
            else sum = sum + 66'(qm);
            // saturate to the coordinate range
            if (sum > 66'sd2147483647) outv[i] = 32'sh7fffffff;
            else if (sum < -66'sd2147483648) outv[i] = 32'sh80000000;
            else outv[i] = sum[31:0];
        end
        rs.new_x = outv[0]; rs.new_y = outv[1]; rs.new_z = outv[2];
        rs.reached = 1'b0;
        return rs;
    endfunction

    // random coordinate: mostly small, sometimes full range or an extreme
    function automatic logic [31:0] rand_coord();
        case ($urandom_range(0, 9))
            0, 1:    return $urandom();
            2:       return $urandom_range(0, 1) ? 32'h7fffffff : 32'h80000000;
            default: return 32'($signed($urandom_range(0, 20'hfffff)) - 32'sh80000);
        endcase
    endfunction

    function automatic req_t rand_req();
        req_t rq;
        rq.cur_x = rand_coord(); rq.cur_y = rand_coord(); rq.cur_z = rand_coord();
        if ($urandom_range(0, 9) == 0) begin
            rq.goal_x = rq.cur_x; rq.goal_y = rq.cur_y; rq.goal_z = rq.cur_z;
        end else begin
            rq.goal_x = rand_coord(); rq.goal_y = rand_coord(); rq.goal_z = rand_coord();
        end
        case ($urandom_range(0, 7))
            0:       rq.step_len = '0;
            1:       rq.step_len = $urandom();
            2:       rq.step_len = -32'($urandom_range(0, 20'hfffff));
            default: rq.step_len = $urandom_range(0, 24'h3fffff);
        endcase
        return rq;
    endfunction

    function automatic req_t make_req(input logic [31:0] cx, cy, cz, gx, gy, gz, st);
        req_t rq;
        rq.cur_x = cx; rq.cur_y = cy; rq.cur_z = cz;
        rq.goal_x = gx; rq.goal_y = gy; rq.goal_z = gz;
        rq.step_len = st;
        return rq;
    endfunction

    // driver: presents queued requests, idles at random
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                expected_moves.push_back(predict_move(s_data));
            end
            if (!s_valid || s_ready) begin
                if (pending_reqs.size() > 0 && !hold_send
                        && (no_idle || $urandom_range(0, 99) >= 15)) begin
                    s_data  <= pending_reqs.pop_front();
                    s_valid <= 1'b1;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: checks every accepted response against the oldest expectation
    always @(posedge aclk) begin
        rsp_t exp_rsp;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_moves.size() == 0) begin
                    $display("%0t: unexpected response %h", $time, m_data);
                    n_errors++;
                end else begin
                    exp_rsp = expected_moves.pop_front();
                    if (m_data.new_x !== exp_rsp.new_x) begin
                        $display("%0t: new_x expected %h actual %h", $time,
                                 exp_rsp.new_x, m_data.new_x);
                        n_errors++;
                    end
                    if (m_data.new_y !== exp_rsp.new_y) begin
                        $display("%0t: new_y expected %h actual %h", $time,
                                 exp_rsp.new_y, m_data.new_y);
                        n_errors++;
                    end
                    if (m_data.new_z !== exp_rsp.new_z) begin
                        $display("%0t: new_z expected %h actual %h", $time,
                                 exp_rsp.new_z, m_data.new_z);
                        n_errors++;
                    end
                    if (m_data.reached !== exp_rsp.reached) begin
                        $display("%0t: reached expected %b actual %b", $time,
                                 exp_rsp.reached, m_data.reached);
                        n_errors++;
                    end
                end
            end
            m_ready <= no_idle || $urandom_range(0, 99) >= 15;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        n_cycles <= n_cycles + 1;
        if (n_cycles > CYCLE_LIMIT) begin
            $display("move_point_towards_target: mismatch");
            $finish;
        end
    end

    initial begin
        // directed: extremes, zero distance, zero step, reach, away, saturation
        pending_reqs.push_back(make_req(0, 0, 0, 0, 0, 0, 32'h80000000));
        pending_reqs.push_back(make_req(1, 2, 3, 1, 2, 3, 32'h7fffffff));
        pending_reqs.push_back(make_req(0, 0, 0, 32'h30000, 32'h40000, 0, 0));
        pending_reqs.push_back(make_req(0, 0, 0, 32'h30000, 32'h40000, 0, 32'h50000));
        pending_reqs.push_back(make_req(0, 0, 0, 32'h30000, 32'h40000, 0, 32'h10000));
        pending_reqs.push_back(make_req(0, 0, 0, 32'h30000, 32'h40000, 0, 32'hffff0000));
        pending_reqs.push_back(make_req(32'h80000000, 32'h80000000, 32'h80000000,
            32'h7fffffff, 32'h7fffffff, 32'h7fffffff, 32'h7fffffff));
        pending_reqs.push_back(make_req(32'h7fffffff, 32'h7fffffff, 32'h7fffffff,
            32'h80000000, 32'h80000000, 32'h80000000, 32'h10000));
        pending_reqs.push_back(make_req(32'h7fff0000, 0, 0, 32'h7ffe0000, 0, 0,
            32'h80000000));
        pending_reqs.push_back(make_req(32'h80010000, 0, 0, 32'h80020000, 0, 0,
            32'h80000000));
        pending_reqs.push_back(make_req(32'hffffffff, 32'hffffffff, 32'hffffffff,
            0, 0, 0, 32'hffffffff));
        pending_reqs.push_back(make_req(0, 0, 0, 1, 0, 0, 1));
        pending_reqs.push_back(make_req(0, 0, 0, 32'h7fffffff, 32'h80000000, 1, 32'h7fffffff));
        pending_reqs.push_back(make_req(5, 32'h1234, 32'hfedc, 32'h8000, 32'h80000000,
            32'h7fffffff, 32'h12345678));
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // wait for directed requests to drain, then pause once more mid-run
        wait (pending_reqs.size() == 0);
        @(posedge aclk);
        hold_send = 1'b1;
        wait (expected_moves.size() == 0 && !s_valid);
        hold_send = 1'b0;

        for (int i = 0; i < N_RANDOM; i++) pending_reqs.push_back(rand_req());
        wait (pending_reqs.size() < 1200);
        no_idle = 1'b1;
        wait (pending_reqs.size() < 900);
        no_idle = 1'b0;
        wait (pending_reqs.size() < 500);
        hold_send = 1'b1;
        wait (expected_moves.size() == 0);
        hold_send = 1'b0;
        wait (pending_reqs.size() == 0);
        @(posedge aclk);
        wait (!s_valid && expected_moves.size() == 0);
        repeat (LATENCY + 20) @(posedge aclk);
        if (n_errors == 0) begin
            $display("move_point_towards_target: match");
        end else begin
            $display("move_point_towards_target: mismatch");
        end
        $finish;
    end
endmodule

`default_nettype wire
